// ===== rtl/mcg_pkg.sv =====
package mcg_pkg;

  localparam int GRID_CELLS = 42;
  localparam logic [5:0] LAST_CELL = 6'(GRID_CELLS - 1);

  // Reciprocal multipliers: x*5243>>19 == x/100 for x < 16784,
  // x*2341>>14 == x/7 for x < 1040
  localparam logic [12:0] RECIP_100 = 13'd5243;
  localparam int RECIP_100_SHIFT = 19;
  localparam logic [11:0] RECIP_7 = 12'd2341;
  localparam int RECIP_7_SHIFT = 14;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
  } in_item_t;

  typedef struct packed {
    logic [5:0] cell_index;
    logic [4:0] day_number;
    logic       in_month;
    logic       last_cell;
  } out_cell_t;

  // One classified page: weekday of day 1 (0 is Saturday) and month lengths
  typedef struct packed {
    logic [2:0] start_wd;
    logic [4:0] len;
    logic [4:0] prev_len;
  } grid_job_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] res;
    unique case (m)
      4'd1:    res = 5'd31;
      4'd2:    res = leap ? 5'd29 : 5'd28;
      4'd3:    res = 5'd31;
      4'd4:    res = 5'd30;
      4'd5:    res = 5'd31;
      4'd6:    res = 5'd30;
      4'd7:    res = 5'd31;
      4'd8:    res = 5'd31;
      4'd9:    res = 5'd30;
      4'd10:   res = 5'd31;
      4'd11:   res = 5'd30;
      4'd12:   res = 5'd31;
      default: res = 5'd31;
    endcase
    return res;
  endfunction

  // Zeller month term (mm+1)*13/5 for mm in 3..14
  function automatic logic [5:0] zeller_month(input logic [3:0] mm);
    logic [5:0] res;
    unique case (mm)
      4'd3:    res = 6'd10;
      4'd4:    res = 6'd13;
      4'd5:    res = 6'd15;
      4'd6:    res = 6'd18;
      4'd7:    res = 6'd20;
      4'd8:    res = 6'd23;
      4'd9:    res = 6'd26;
      4'd10:   res = 6'd28;
      4'd11:   res = 6'd31;
      4'd12:   res = 6'd33;
      4'd13:   res = 6'd36;
      4'd14:   res = 6'd39;
      default: res = 6'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/mcg_front.sv =====
module mcg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  mcg_pkg::in_item_t   item,
  output logic                push,
  output mcg_pkg::grid_job_t  job
);

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;

  logic [13:0] year1_r;
  logic [3:0]  month1_r;

  logic [13:0] year2_r;
  logic [3:0]  month2_r;
  logic [3:0]  mm2_r;
  logic [14:0] yy2_r;
  logic [7:0]  cent2_r;
  logic [7:0]  ycent2_r;

  logic [6:0]  rem3_r;
  logic [9:0]  part3_r;
  logic [4:0]  len3_r, prev3_r;

  logic [10:0] sum4_r;
  logic [4:0]  len4_r, prev4_r;

  logic [10:0] sum5_r;
  logic [7:0]  q5_r;
  logic [4:0]  len5_r, prev5_r;

  logic [3:0]  month_sat;
  logic        early;
  logic [14:0] yy_nxt;
  logic [27:0] cprod, yprod;
  logic [14:0] rem_full, yrem_full;
  logic [6:0]  yrem;
  logic        leap;
  logic [3:0]  prev_month;
  logic [21:0] qprod;
  logic [10:0] wd_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Saturate month into 1..12
  always_comb begin
    if (item.month < mcg_pkg::MONTH_JAN) begin
      month_sat = mcg_pkg::MONTH_JAN;
    end else if (item.month > mcg_pkg::MONTH_DEC) begin
      month_sat = mcg_pkg::MONTH_DEC;
    end else begin
      month_sat = item.month;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      year1_r  <= item.year;
      month1_r <= month_sat;
    end
  end

  // Shift January and February into the previous year, offset by 400 years
  assign early  = (month1_r <= mcg_pkg::MONTH_FEB);
  assign yy_nxt = {1'b0, year1_r} + 15'd400 - {14'd0, early};
  assign cprod  = {13'd0, yy_nxt} * {15'd0, mcg_pkg::RECIP_100};
  assign yprod  = {14'd0, year1_r} * {15'd0, mcg_pkg::RECIP_100};

  always_ff @(posedge clk) begin
    year2_r  <= year1_r;
    month2_r <= month1_r;
    mm2_r    <= early ? month1_r + 4'd12 : month1_r;
    yy2_r    <= yy_nxt;
    cent2_r  <= cprod[mcg_pkg::RECIP_100_SHIFT +: 8];
    ycent2_r <= yprod[mcg_pkg::RECIP_100_SHIFT +: 8];
  end

  assign rem_full  = yy2_r - {7'd0, cent2_r} * 15'd100;
  assign yrem_full = {1'b0, year2_r} - {7'd0, ycent2_r} * 15'd100;
  assign yrem      = yrem_full[6:0];
  assign leap      = ((year2_r[1:0] == 2'd0) && (yrem != 7'd0)) ||
                     ((yrem == 7'd0) && (ycent2_r[1:0] == 2'd0));
  assign prev_month = month2_r - 4'd1;

  always_ff @(posedge clk) begin
    rem3_r  <= rem_full[6:0];
    part3_r <= 10'd1 + {4'd0, mcg_pkg::zeller_month(mm2_r)} + {4'd0, cent2_r[7:2]}
               + {2'd0, cent2_r} * 10'd5;
    len3_r  <= mcg_pkg::month_len(month2_r, leap);
    prev3_r <= (month2_r == mcg_pkg::MONTH_JAN) ? 5'd31
                                                 : mcg_pkg::month_len(prev_month, leap);
  end

  always_ff @(posedge clk) begin
    sum4_r  <= {1'b0, part3_r} + {4'd0, rem3_r} + {6'd0, rem3_r[6:2]};
    len4_r  <= len3_r;
    prev4_r <= prev3_r;
  end

  assign qprod = {11'd0, sum4_r} * {10'd0, mcg_pkg::RECIP_7};

  always_ff @(posedge clk) begin
    sum5_r  <= sum4_r;
    q5_r    <= qprod[mcg_pkg::RECIP_7_SHIFT +: 8];
    len5_r  <= len4_r;
    prev5_r <= prev4_r;
  end

  assign wd_full      = sum5_r - {3'd0, q5_r} * 11'd7;
  assign push         = v5_r;
  assign job.start_wd = wd_full[2:0];
  assign job.len      = len5_r;
  assign job.prev_len = prev5_r;

endmodule

// ===== rtl/mcg_fifo.sv =====
module mcg_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mcg_pkg::grid_job_t  wr_data,
  input  logic                pop,
  output logic                not_empty,
  output mcg_pkg::grid_job_t  rd_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mcg_pkg::grid_job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  assign not_empty = (count_r != '0);
  assign rd_data   = mem[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != CW'(DEPTH)) || pop)
    else $error("job queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("job queue read while empty");

endmodule

// ===== rtl/mcg_back.sv =====
module mcg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_avail,
  input  mcg_pkg::grid_job_t  job,
  output logic                pop,
  output logic                out_strobe,
  output mcg_pkg::out_cell_t  out_cell
);

  mcg_pkg::grid_job_t job_r;
  logic               active_r;
  logic [5:0]         cnt_r;
  logic               strobe_r;
  mcg_pkg::out_cell_t cell_r;

  logic               at_last;
  logic               lead;
  logic [6:0]         lead_day;
  logic [6:0]         d;
  logic               inm;
  logic [6:0]         day;
  mcg_pkg::out_cell_t cell_nxt;

  assign at_last = (cnt_r == mcg_pkg::LAST_CELL);
  assign pop     = job_avail && (!active_r || at_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
    end else if (pop) begin
      active_r <= 1'b1;
      cnt_r    <= '0;
    end else if (active_r) begin
      if (at_last) begin
        active_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
    end
  end

  // Leading cells count up to the previous month's last day
  assign lead     = ({1'b0, cnt_r} < {4'd0, job_r.start_wd});
  assign lead_day = {2'd0, job_r.prev_len} + 7'd1 + {1'b0, cnt_r} - {4'd0, job_r.start_wd};
  assign d        = {1'b0, cnt_r} + 7'd1 - {4'd0, job_r.start_wd};
  assign inm      = !lead && (d <= {2'd0, job_r.len});

  always_comb begin
    if (lead) begin
      day = lead_day;
    end else if (inm) begin
      day = d;
    end else begin
      day = d - {2'd0, job_r.len};
    end
  end

  always_comb begin
    cell_nxt.cell_index = cnt_r;
    cell_nxt.day_number = day[4:0];
    cell_nxt.in_month   = inm;
    cell_nxt.last_cell  = at_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (active_r) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_strobe = strobe_r;
  assign out_cell   = cell_r;

  a_grid_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && !cell_r.last_cell) |=> strobe_r)
    else $error("grid interrupted before its last cell");

  a_cells_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (strobe_r && (cell_r.cell_index != 6'd0)) |->
      ($past(strobe_r) && ($past(cell_r.cell_index) + 6'd1 == cell_r.cell_index)))
    else $error("grid cell out of order");

endmodule

// ===== rtl/month_calendar_grid.sv =====
// Month page generator: one (year, month) item gives 42 grid cells, one per cycle.
// The front pipeline classifies an item in its registered stages; the job then waits in the
// job queue, and the grid generator takes the next job only at the last cell of the one before.
// New items are accepted meanwhile until the queue's entries are all in flight, then busy is set.
// Reset: synchronous, active low; clears the pipeline, job queue and counter.
// The receiver cannot stall: a cell is shown for exactly one cycle.
module month_calendar_grid #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mcg_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output mcg_pkg::out_cell_t out_cell
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic               acc;
  logic               push;
  logic               pop;
  logic               job_avail;
  mcg_pkg::grid_job_t fr_job;
  mcg_pkg::grid_job_t q_job;
  logic [CW-1:0]      inflight_r;

  // Count items accepted but not yet taken by the grid generator,
  // so the queue always has room for everything in the front pipeline
  assign busy = (inflight_r == CW'(QUEUE_DEPTH));
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (acc && !pop) begin
      inflight_r <= inflight_r + CW'(1);
    end else if (pop && !acc) begin
      inflight_r <= inflight_r - CW'(1);
    end
  end

  mcg_front u_front (
    .clk  (clk),
    .rst_n(rst_n),
    .acc  (acc),
    .item (in_item),
    .push (push),
    .job  (fr_job)
  );

  mcg_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_data  (fr_job),
    .pop      (pop),
    .not_empty(job_avail),
    .rd_data  (q_job)
  );

  mcg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_avail (job_avail),
    .job       (q_job),
    .pop       (pop),
    .out_strobe(out_strobe),
    .out_cell  (out_cell)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CW'(QUEUE_DEPTH))
    else $error("more items in flight than queue entries");

endmodule

// ===== dv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PAGES = 400;
  localparam int MAX_LINES = 60;
  localparam int DRAIN_CYCLES = 16;

  // Directed pages; where typed is set, the weekday of day 1 and the month
  // lengths are given here instead of being worked out by the predictor.
  typedef struct {
    int year;
    int month;
    bit typed;
    int wd;
    int len;
    int prev_len;
  } page_row_t;

  localparam int DIR_ROWS = 24;
  page_row_t page_rows [DIR_ROWS] = '{
    '{2000,  1, 1, 0, 31, 31},
    '{2000,  2, 1, 3, 29, 31},
    '{2000,  0, 1, 0, 31, 31},   // month zero saturates to January
    '{2000, 15, 1, 6, 31, 30},   // month above twelve saturates to December
    '{2023,  2, 1, 4, 28, 31},
    '{1900,  2, 0, 0, 0, 0},
    '{1900,  3, 0, 0, 0, 0},
    '{1600,  3, 0, 0, 0, 0},
    '{   1,  1, 0, 0, 0, 0},
    '{9999, 12, 0, 0, 0, 0},
    '{   0,  1, 0, 0, 0, 0},
    '{   0,  2, 0, 0, 0, 0},
    '{   0,  3, 0, 0, 0, 0},
    '{16383, 0, 0, 0, 0, 0},
    '{16383, 15, 0, 0, 0, 0},
    '{10000, 3, 0, 0, 0, 0},
    '{2023,  4, 0, 0, 0, 0},
    '{2023,  5, 0, 0, 0, 0},
    '{2023,  6, 0, 0, 0, 0},
    '{2023,  7, 0, 0, 0, 0},
    '{2023,  8, 0, 0, 0, 0},
    '{2023,  9, 0, 0, 0, 0},
    '{2023, 10, 0, 0, 0, 0},
    '{2023, 11, 0, 0, 0, 0}
  };

  localparam int DAYS_PER_MONTH [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  mcg_pkg::in_item_t  in_item;
  logic               out_strobe;
  mcg_pkg::out_cell_t out_cell;

  mcg_pkg::out_cell_t pending_cells [$];
  mcg_pkg::out_cell_t want;
  int                 mismatches;
  int                 cycle_count;

  month_calendar_grid uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_cell   (out_cell)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function automatic bit is_leap_year(input int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int days_in(input int y, input int m);
    if (m == 2 && is_leap_year(y)) return 29;
    return DAYS_PER_MONTH[m - 1];
  endfunction

  function automatic mcg_pkg::grid_job_t classify_page(input mcg_pkg::in_item_t item);
    mcg_pkg::grid_job_t job;
    int y;
    int m;
    int yy;
    int mm;
    int cent;
    int rem;
    y = int'(item.year);
    m = int'(item.month);
    if (m < 1) m = 1;
    if (m > 12) m = 12;
    job.len = 5'(days_in(y, m));
    job.prev_len = (m == 1) ? 5'd31 : 5'(days_in(y, m - 1));
    // Zeller on day 1, shifted by 400 years so year 0 needs no negative year
    yy = y + 400;
    mm = m;
    if (mm <= 2) begin
      yy = yy - 1;
      mm = mm + 12;
    end
    cent = yy / 100;
    rem = yy % 100;
    job.start_wd = 3'((1 + ((mm + 1) * 13) / 5 + rem + rem / 4 + cent / 4 + 5 * cent) % 7);
    return job;
  endfunction

  task automatic queue_page_cells(input mcg_pkg::grid_job_t job);
    mcg_pkg::out_cell_t exp_cell;
    int wd;
    int d;
    wd = int'(job.start_wd);
    for (int c = 0; c < mcg_pkg::GRID_CELLS; c++) begin
      exp_cell.cell_index = 6'(c);
      exp_cell.last_cell = (c == mcg_pkg::GRID_CELLS - 1);
      if (c < wd) begin
        exp_cell.day_number = 5'(int'(job.prev_len) - (wd - 1 - c));
        exp_cell.in_month = 1'b0;
      end else begin
        d = c - wd + 1;
        exp_cell.in_month = (d <= int'(job.len));
        exp_cell.day_number = exp_cell.in_month ? 5'(d) : 5'(d - int'(job.len));
      end
      pending_cells.push_back(exp_cell);
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Present one page request and hold it until accepted
  task automatic issue_page(input mcg_pkg::in_item_t item, input bit allow_gap);
    if (allow_gap && $urandom_range(99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_item <= item;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_cells.size() == 0) begin
        report_mismatch($sformatf("unexpected cell %0d", out_cell.cell_index));
      end else begin
        want = pending_cells.pop_front();
        if (out_cell.cell_index !== want.cell_index)
          report_mismatch($sformatf("cell_index %0d, want %0d",
                                    out_cell.cell_index, want.cell_index));
        if (out_cell.day_number !== want.day_number)
          report_mismatch($sformatf("cell %0d day_number %0d, want %0d",
                                    want.cell_index, out_cell.day_number, want.day_number));
        if (out_cell.in_month !== want.in_month)
          report_mismatch($sformatf("cell %0d in_month %b, want %b",
                                    want.cell_index, out_cell.in_month, want.in_month));
        if (out_cell.last_cell !== want.last_cell)
          report_mismatch($sformatf("cell %0d last_cell %b, want %b",
                                    want.cell_index, out_cell.last_cell, want.last_cell));
      end
    end
  end

  initial begin
    mcg_pkg::in_item_t  item;
    mcg_pkg::grid_job_t job;
    int                 pick;
    mismatches = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (page_rows[i]) begin
      item.year = 14'(page_rows[i].year);
      item.month = 4'(page_rows[i].month);
      issue_page(item, 1'b1);
      if (page_rows[i].typed) begin
        job.start_wd = 3'(page_rows[i].wd);
        job.len = 5'(page_rows[i].len);
        job.prev_len = 5'(page_rows[i].prev_len);
      end else begin
        job = classify_page(item);
      end
      queue_page_cells(job);
    end

    for (int i = 0; i < RANDOM_PAGES; i++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // anything the field widths allow
        item.year = 14'($urandom_range(16383));
        item.month = 4'($urandom_range(15));
      end else if (pick < 22) begin
        // century years around February, where the leap rule bites
        item.year = 14'($urandom_range(0, 99) * 100);
        item.month = 4'($urandom_range(1, 3));
      end else begin
        item.year = 14'($urandom_range(1, 9999));
        item.month = 4'($urandom_range(1, 12));
      end
      // keep a long stretch free of gaps
      issue_page(item, !(i >= 150 && i < 250));
      queue_page_cells(classify_page(item));
    end
    start <= 1'b0;

    while (pending_cells.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mcg_pkg.sv
rtl/mcg_front.sv
rtl/mcg_fifo.sv
rtl/mcg_back.sv
rtl/month_calendar_grid.sv
dv/tb.sv
